### hw/rtl/drq_pkg.sv
package drq_pkg;

  localparam int FRAME_BITS  = 32;
  localparam int HID_BITS    = 16;
  localparam int MARGIN_BITS = 8;

  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 8'd3;

  localparam logic FUNC_RETIRE  = 1'b0;
  localparam logic FUNC_COLLECT = 1'b1;

  localparam logic STATUS_RELEASE = 1'b0;
  localparam logic STATUS_DROP    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DROP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FLUSH,
    S_CMP_RD,
    S_CMP_WR
  } drq_state_t;

endpackage

### hw/rtl/drq_req_if.sv
interface drq_req_if;
  import drq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  func;
  logic [HID_BITS-1:0]   handle_id;
  logic [FRAME_BITS-1:0] frame_now;
  logic                  force_drain;

  modport source (
    output valid, func, handle_id, frame_now, force_drain,
    input  ready
  );

  modport sink (
    input  valid, func, handle_id, frame_now, force_drain,
    output ready
  );

endinterface

### hw/rtl/drq_rsp_if.sv
interface drq_rsp_if;
  import drq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  status;
  logic [HID_BITS-1:0]   released_id;
  logic [FRAME_BITS-1:0] release_frame;
  logic                  last;

  modport source (
    output valid, status, released_id, release_frame, last,
    input  ready
  );

  modport sink (
    input  valid, status, released_id, release_frame, last,
    output ready
  );

endinterface

### hw/rtl/drq_mem.sv
module drq_mem #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/drq_due_cmp.sv
module drq_due_cmp (
  input  logic [drq_pkg::FRAME_BITS-1:0]  stamp,
  input  logic [drq_pkg::MARGIN_BITS-1:0] margin,
  input  logic [drq_pkg::FRAME_BITS-1:0]  frame_now,
  input  logic                            force_drain,
  output logic                            take
);
  import drq_pkg::*;

  logic [FRAME_BITS-1:0] due;

  // due frame wraps modulo 2^32
  assign due  = stamp + FRAME_BITS'(margin);
  assign take = force_drain || (frame_now >= due);

endmodule

### hw/rtl/deferred_release_queue_unit.sv
// Deferred release queue: holds up to DEPTH retired handle ids, each stamped
// with the current frame at retire time. A retire request gives no result,
// unless the queue is full, in which case one drop result (status 1) is sent
// once the output register is free. A collect request stores frame_now as the
// current frame, then walks the N held entries newest to oldest through one
// shared due-frame compare, reading each entry in S_SCAN_RD and checking it in
// S_SCAN_CHK, since the entry store is a single memory with a registered read.
// Released ids go out newest first, with last on the oldest one released. The
// walk waits while a released id cannot move on to the output register. When
// any entry was released, a second walk oldest to newest compacts the kept
// entries through S_CMP_RD and S_CMP_WR. Input is not accepted until the
// collect is finished. The margin register resets to 3.
module deferred_release_queue_unit #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  drq_req_if.sink                       req,
  drq_rsp_if.source                     rsp,
  input  logic                          cfg_wr_en,
  input  logic [drq_pkg::MARGIN_BITS-1:0] cfg_wr_data
);
  import drq_pkg::*;

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int WIDTH = ID_BITS + FRAME_BITS;

  drq_state_t state, state_next;

  logic [CW-1:0]          count;
  logic [FRAME_BITS-1:0]  current_frame;
  logic [MARGIN_BITS-1:0] margin;
  logic [AW-1:0]          idx;
  logic [CW-1:0]          keep;
  logic [DEPTH-1:0]       take_vec;
  logic                   force_q;

  logic                  hold_valid;
  logic                  hold_status;
  logic [HID_BITS-1:0]   hold_id;

  logic                  out_valid;
  logic                  out_status;
  logic [HID_BITS-1:0]   out_id;
  logic [FRAME_BITS-1:0] out_frame;
  logic                  out_last;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WIDTH-1:0]      mem_wdata;
  logic [WIDTH-1:0]      mem_rdata;
  logic [ID_BITS-1:0]    rd_id;
  logic [FRAME_BITS-1:0] rd_frame;

  logic                  accept;
  logic                  full;
  logic                  slot_free;
  logic                  take;
  logic                  scan_adv;
  logic                  hold_load;
  logic                  hold_status_in;
  logic [HID_BITS-1:0]   hold_id_in;
  logic                  move_out;
  logic                  move_last;
  logic [AW-1:0]         last_idx;
  logic [CW-1:0]         keep_next;

  assign accept    = req.valid && req.ready;
  assign full      = (count == CW'(DEPTH));
  assign slot_free = !out_valid || rsp.ready;
  assign rd_frame  = mem_rdata[FRAME_BITS-1:0];
  assign rd_id     = mem_rdata[WIDTH-1:FRAME_BITS];
  assign last_idx  = AW'(count - CW'(1));
  assign keep_next = take_vec[idx] ? keep : keep + CW'(1);

  drq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  drq_due_cmp u_cmp (
    .stamp       (rd_frame),
    .margin      (margin),
    .frame_now   (current_frame),
    .force_drain (force_q),
    .take        (take)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.func == FUNC_RETIRE) begin
            if (full) begin
              state_next = S_DROP;
            end
          end else if (count != '0) begin
            state_next = S_SCAN_RD;
          end
        end
      end
      S_DROP: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (scan_adv) begin
          state_next = (idx == '0) ? S_FLUSH : S_SCAN_RD;
        end
      end
      S_FLUSH: begin
        if (!hold_valid) begin
          state_next = S_IDLE;
        end else if (slot_free) begin
          state_next = S_CMP_RD;
        end
      end
      S_CMP_RD: state_next = S_CMP_WR;
      S_CMP_WR: state_next = (idx == last_idx) ? S_IDLE : S_CMP_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready      = (state == S_IDLE);
    mem_we         = 1'b0;
    mem_waddr      = count[AW-1:0];
    mem_wdata      = {ID_BITS'(req.handle_id), current_frame};
    hold_load      = 1'b0;
    hold_status_in = STATUS_RELEASE;
    hold_id_in     = req.handle_id;
    move_out       = 1'b0;
    move_last      = 1'b0;
    scan_adv       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && (req.func == FUNC_RETIRE)) begin
          if (full) begin
            hold_load      = 1'b1;
            hold_status_in = STATUS_DROP;
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      S_DROP: begin
        move_out  = slot_free;
        move_last = 1'b1;
      end
      S_SCAN_RD: ;
      S_SCAN_CHK: begin
        scan_adv   = !take || !hold_valid || slot_free;
        hold_id_in = HID_BITS'(rd_id);
        if (scan_adv && take) begin
          hold_load = 1'b1;
          move_out  = hold_valid;
        end
      end
      S_FLUSH: begin
        move_out  = hold_valid && slot_free;
        move_last = 1'b1;
      end
      S_CMP_RD: ;
      S_CMP_WR: begin
        mem_we    = !take_vec[idx];
        mem_waddr = keep[AW-1:0];
        mem_wdata = mem_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET;
    end else if (cfg_wr_en) begin
      margin <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      current_frame <= '0;
    end else begin
      if (accept && (req.func == FUNC_RETIRE) && !full) begin
        count <= count + CW'(1);
      end
      if (accept && (req.func == FUNC_COLLECT)) begin
        current_frame <= req.frame_now;
      end
      if ((state == S_CMP_WR) && (idx == last_idx)) begin
        count <= keep_next;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept && (req.func == FUNC_COLLECT)) begin
          idx      <= last_idx;
          take_vec <= '0;
          force_q  <= req.force_drain;
        end
      end
      S_SCAN_CHK: begin
        if (scan_adv) begin
          take_vec[idx] <= take;
          if (idx != '0) begin
            idx <= idx - AW'(1);
          end
        end
      end
      S_FLUSH: begin
        idx  <= '0;
        keep <= '0;
      end
      S_CMP_WR: begin
        keep <= keep_next;
        if (idx != last_idx) begin
          idx <= idx + AW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (hold_load) begin
      hold_valid <= 1'b1;
    end else if (move_out) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_status <= hold_status_in;
      hold_id     <= hold_id_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move_out) begin
      out_status <= hold_status;
      out_id     <= hold_id;
      out_frame  <= current_frame;
      out_last   <= move_last;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.released_id   = out_id;
  assign rsp.release_frame = out_frame;
  assign rsp.last          = out_last;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import drq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int HANDLE_BITS = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic                  func;
    logic [HID_BITS-1:0]   handle_id;
    logic [FRAME_BITS-1:0] frame_now;
    logic                  force_drain;
  } request_t;

  typedef struct {
    logic                  status;
    logic [HID_BITS-1:0]   released_id;
    logic [FRAME_BITS-1:0] release_frame;
    logic                  last;
  } release_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [MARGIN_BITS-1:0] cfg_wr_data;
  logic rsp_hold;
  bit hold_go;

  drq_req_if req_ch ();
  drq_rsp_if rsp_ch ();

  deferred_release_queue_unit #(
    .DEPTH   (QUEUE_DEPTH),
    .ID_BITS (HANDLE_BITS)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  request_t pending_requests[$];
  release_t expected_releases[$];

  // shadow of the queue contents
  logic [HID_BITS-1:0]    held_id [QUEUE_DEPTH];
  logic [FRAME_BITS-1:0]  held_frame [QUEUE_DEPTH];
  int                     held_count;
  logic [FRAME_BITS-1:0]  cur_frame;
  logic [MARGIN_BITS-1:0] margin;

  int src_max;
  int snk_max;
  int src_wait;
  int snk_wait;
  int fail_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic predict_reclaim(input logic fn, input logic [HID_BITS-1:0] hid,
                                 input logic [FRAME_BITS-1:0] now, input logic fd);
    release_t r;
    logic take [QUEUE_DEPTH];
    logic [FRAME_BITS-1:0] due;
    int keep;
    int n;
    n = 0;
    if (fn == FUNC_RETIRE) begin
      if (held_count < QUEUE_DEPTH) begin
        held_id[held_count] = hid;
        held_frame[held_count] = cur_frame;
        held_count++;
      end else begin
        r = '{STATUS_DROP, hid, cur_frame, 1'b1};
        expected_releases = {expected_releases, r};
      end
    end else begin
      cur_frame = now;
      // newest first
      for (int i = held_count - 1; i >= 0; i--) begin
        due = held_frame[i] + FRAME_BITS'(margin);
        take[i] = fd || (now >= due);
        if (take[i]) begin
          r = '{STATUS_RELEASE, held_id[i], now, 1'b0};
          expected_releases = {expected_releases, r};
          n++;
        end
      end
      if (n > 0) expected_releases[expected_releases.size() - 1].last = 1'b1;
      keep = 0;
      for (int i = 0; i < held_count; i++) begin
        if (!take[i]) begin
          held_id[keep] = held_id[i];
          held_frame[keep] = held_frame[i];
          keep++;
        end
      end
      held_count = keep;
    end
  endtask

  task automatic check_release(input logic st, input logic [HID_BITS-1:0] id,
                               input logic [FRAME_BITS-1:0] fr, input logic lst);
    release_t want;
    if (expected_releases.size() == 0) begin
      report_mismatch($sformatf("unexpected result st %b id %h frame %h last %b",
                                st, id, fr, lst));
    end else begin
      want = expected_releases.pop_front();
      if (st !== want.status || id !== want.released_id ||
          fr !== want.release_frame || lst !== want.last)
        report_mismatch($sformatf(
          "got st %b id %h frame %h last %b, want st %b id %h frame %h last %b",
          st, id, fr, lst, want.status, want.released_id, want.release_frame,
          want.last));
    end
  endtask

  task automatic push_retire(input logic [HID_BITS-1:0] id);
    request_t q;
    q = '{FUNC_RETIRE, id, $urandom, 1'($urandom_range(0, 1))};
    pending_requests = {pending_requests, q};
  endtask

  task automatic push_collect(input logic [FRAME_BITS-1:0] fr, input logic fd);
    request_t q;
    q = '{FUNC_COLLECT, HID_BITS'($urandom), fr, fd};
    pending_requests = {pending_requests, q};
  endtask

  // mostly advancing frames with bursts of retires, some jumps in frame
  task automatic queue_random_traffic(input int count, input logic [FRAME_BITS-1:0] start,
                                      input int step_max);
    logic [FRAME_BITS-1:0] t;
    int pick;
    int burst;
    t = start;
    while (count > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_retire(HID_BITS'($urandom));
        count--;
      end else if (pick < 85) begin
        t += FRAME_BITS'($urandom_range(0, step_max));
        push_collect(t, $urandom_range(0, 11) == 0);
        count--;
      end else if (pick < 92) begin
        burst = $urandom_range(8, 18);
        repeat (burst) push_retire(HID_BITS'($urandom));
        count -= burst;
      end else begin
        push_collect($urandom, 1'($urandom_range(0, 1)));
        count--;
      end
    end
  endtask

  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_requests.size() != 0 || req_ch.valid || expected_releases.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_margin(input logic [MARGIN_BITS-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    margin = value;
  endtask

  // request driver
  always @(posedge clk) begin
    request_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
      src_wait = 0;
    end else begin
      if (req_ch.valid && req_ch.ready)
        predict_reclaim(req_ch.func, req_ch.handle_id, req_ch.frame_now, req_ch.force_drain);
      if (req_ch.valid && !req_ch.ready) begin
        // hold the offered request
      end else if (src_wait > 0) begin
        src_wait--;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        nxt = pending_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.func <= nxt.func;
        req_ch.handle_id <= nxt.handle_id;
        req_ch.frame_now <= nxt.frame_now;
        req_ch.force_drain <= nxt.force_drain;
        src_wait = $urandom_range(0, src_max);
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        check_release(rsp_ch.status, rsp_ch.released_id, rsp_ch.release_frame, rsp_ch.last);
        snk_wait = $urandom_range(0, snk_max);
      end else if (rsp_ch.valid && snk_wait > 0) begin
        snk_wait--;
      end
      rsp_ch.ready <= !rsp_hold && snk_wait == 0;
    end
  end

  // long receiver hold-off so the block backs up
  initial begin
    rsp_hold = 1'b0;
    wait (hold_go);
    repeat (20) @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int m;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_RETIRE;
    req_ch.handle_id = '0;
    req_ch.frame_now = '0;
    req_ch.force_drain = 1'b0;
    rsp_ch.ready = 1'b0;
    hold_go = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    held_count = 0;
    cur_frame = '0;
    margin = MARGIN_RESET;
    src_max = 6;
    snk_max = 6;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty collect, not yet due, due, fill, drops on full, forced drain
    push_collect(32'd0, 1'b0);
    push_retire(16'h0000);
    push_retire(16'hFFFF);
    push_collect(32'd2, 1'b0);
    push_collect(32'd3, 1'b0);
    for (int i = 0; i < QUEUE_DEPTH; i++) push_retire(HID_BITS'(1) << i);
    push_retire(16'hA5A5);
    push_retire(16'h5A5A);
    push_collect(32'd4, 1'b1);
    wait_quiet();

    // widest margin, due frame wraps past the top
    set_margin(8'd255);
    push_collect(32'hFFFF_FF80, 1'b0);
    push_retire(16'h1234);
    push_collect(32'hFFFF_FF90, 1'b0);
    queue_random_traffic(45, $urandom, 90);
    wait_quiet();

    set_margin(8'd0);
    src_max = 0;
    snk_max = 0;
    queue_random_traffic(45, $urandom, 2);
    wait_quiet();

    set_margin(8'd5);
    src_max = 1;
    snk_max = 6;
    hold_go = 1'b1;
    queue_random_traffic(55, $urandom, 4);
    wait_quiet();

    m = $urandom_range(2, 254);
    set_margin(MARGIN_BITS'(m));
    src_max = 6;
    snk_max = 6;
    queue_random_traffic(45, 32'hFFFF_FF00, m / 3 + 2);
    wait_quiet();

    set_margin(8'd1);
    src_max = 6;
    snk_max = 0;
    queue_random_traffic(50, $urandom, 3);
    wait_quiet();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/drq_pkg.sv
hw/rtl/drq_req_if.sv
hw/rtl/drq_rsp_if.sv
hw/rtl/drq_mem.sv
hw/rtl/drq_due_cmp.sv
hw/rtl/deferred_release_queue_unit.sv
test/testbench.sv
